>>> hw/rtl/iit_pkg.sv
package iit_pkg;

  localparam int TABLE_SLOTS_DEF  = 1024;
  localparam int MAX_NAME_LEN_DEF = 32;

  localparam int CH_W     = 8;
  localparam int IDENT_W  = 10;
  localparam int STATUS_W = 2;
  localparam int SLOTS_W  = 11;
  localparam int HASH_W   = 64;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 2;

  localparam logic [HASH_W-1:0]  HASH_MUL    = 64'h517cc1b727220a95;
  localparam logic [SLOTS_W-1:0] SLOTS_RESET = 11'd1024;

  localparam logic [PADDR_W-1:0] REG_SLOTS_IN_USE = 2'd0;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

endpackage

>>> hw/rtl/iit_if.sv
interface iit_char_if;
  import iit_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last_char;
  logic            skip;
  modport source (output valid, ch, last_char, skip, input ready);
  modport sink   (input valid, ch, last_char, skip, output ready);
endinterface

interface iit_res_if;
  import iit_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDENT_W-1:0]  sym_id;
  logic                is_new;
  logic [STATUS_W-1:0] status;
  modport source (output valid, sym_id, is_new, status, input ready);
  modport sink   (input valid, sym_id, is_new, status, output ready);
endinterface

>>> hw/rtl/iit_ram.sv
module iit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/identifier_interning_table.sv
// Identifier interning table.
// chars (sink): one identifier byte per transaction with last_char on the
// final byte; transactions with skip set are consumed and change nothing.
// result (source): one transaction per identifier, carrying sym_id, is_new
// and status (ok, table full, too long). APB register 0 is slots_in_use.
// Each accepted byte runs the 64-bit hash update: three 32x32 products in
// turn, then a final add. On the last byte of a name that is not too long a
// bit-serial remainder unit finds hash mod slots_in_use (0 acts as 1, capped
// at TABLE_SLOTS); each probe then reads the slot memory and, on a hash and
// length match, compares the name byte by byte; an insert copies the name.
// The result sits in an output register; if the receiver stalls, the block
// holds the next finished result and takes no new byte until it moves in.
// After reset the block clears the slot memory, one slot per cycle, through
// all TABLE_SLOTS slots; chars.ready stays low during that pass, while register
// writes are taken as ever.
module identifier_interning_table #(
  parameter int TABLE_SLOTS  = iit_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_NAME_LEN = iit_pkg::MAX_NAME_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  iit_char_if.sink                     chars,
  iit_res_if.source                    result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [iit_pkg::PADDR_W-1:0]  paddr,
  input  logic [iit_pkg::PDATA_W-1:0]  pwdata,
  output logic [iit_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import iit_pkg::*;

  localparam int IW  = $clog2(TABLE_SLOTS);
  localparam int NW  = $clog2(TABLE_SLOTS + 1);
  localparam int LW  = $clog2(MAX_NAME_LEN + 2);
  localparam int KW  = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int NAW = $clog2(TABLE_SLOTS * MAX_NAME_LEN);
  localparam int SW  = 1 + HASH_W + LW + NW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MA, S_MB, S_MC, S_SUM, S_DIV,
    S_PRD, S_PCHK, S_CRD, S_CCHK, S_COPY, S_EMIT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [LW-1:0]     len;
    logic [NW-1:0]     num;
  } slot_t;

  state_t             state;
  logic [SLOTS_W-1:0] slots_in_use;
  logic [HASH_W-1:0]  h;
  logic [HASH_W-1:0]  x;
  logic [HASH_W-1:0]  p0;
  logic [31:0]        p1;
  logic [31:0]        p2;
  logic [LW-1:0]      klen;
  logic               lastf;
  logic [CH_W-1:0]    kbuf [MAX_NAME_LEN];
  logic [NW-1:0]      next_number;
  logic [IW:0]        nreg;
  logic [IW:0]        n_eff;
  logic [IW:0]        rem;
  logic [IW+1:0]      trial;
  logic [IW:0]        rem_next;
  logic [5:0]         bitcnt;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      clr;
  logic [IW:0]        probes;
  logic [LW-1:0]      ci;
  logic [NW-1:0]      snum;
  logic [NW-1:0]      res_id;
  logic               res_new;
  logic [STATUS_W-1:0] res_status;

  logic               slot_we;
  logic [IW-1:0]      slot_waddr;
  slot_t              slot_wdata;
  slot_t              slot_rdata;
  logic               name_we;
  logic [NAW-1:0]     name_waddr;
  logic [NAW-1:0]     name_raddr;
  logic [CH_W-1:0]    name_rdata;
  logic               cfg_we;
  logic [IW:0]        idx_inc;
  logic [IW-1:0]      idx_wrap;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_SLOTS_IN_USE);
  assign prdata = (paddr == REG_SLOTS_IN_USE) ? PDATA_W'(slots_in_use) : '0;

  always_comb begin
    if (slots_in_use == '0) begin
      n_eff = (IW+1)'(1);
    end else if (32'(slots_in_use) > 32'(TABLE_SLOTS)) begin
      n_eff = (IW+1)'(TABLE_SLOTS);
    end else begin
      n_eff = (IW+1)'(slots_in_use);
    end
  end

  assign trial    = {rem, h[bitcnt]};
  assign rem_next = (trial >= {1'b0, nreg}) ? (IW+1)'(trial - {1'b0, nreg}) : trial[IW:0];
  assign idx_inc  = (IW+1)'(idx) + (IW+1)'(1);
  assign idx_wrap = (idx_inc >= nreg) ? '0 : idx_inc[IW-1:0];

  assign chars.ready = (state == S_IDLE);

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = idx;
    slot_wdata = '0;
    if (state == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr;
    end else if (state == S_PCHK && !slot_rdata.valid && 32'(next_number) < 32'(TABLE_SLOTS)) begin
      slot_we    = 1'b1;
      slot_wdata = '{valid: 1'b1, hash: h, len: klen, num: next_number};
    end
  end

  assign name_we    = (state == S_COPY);
  assign name_waddr = NAW'(NAW'(next_number) * NAW'(MAX_NAME_LEN) + NAW'(ci));
  assign name_raddr = NAW'(NAW'(snum) * NAW'(MAX_NAME_LEN) + NAW'(ci));

  iit_ram #(.WIDTH(SW), .DEPTH(TABLE_SLOTS)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (idx),
    .rdata (slot_rdata)
  );

  iit_ram #(.WIDTH(CH_W), .DEPTH(TABLE_SLOTS * MAX_NAME_LEN)) u_names (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (kbuf[ci[KW-1:0]]),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      slots_in_use <= SLOTS_RESET;
      h            <= '0;
      klen         <= '0;
      next_number  <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use <= pwdata[SLOTS_W-1:0];
      end
      if (result.valid && result.ready && state != S_EMIT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == 32'(TABLE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (chars.valid && !chars.skip) begin
            x     <= {h[HASH_W-6:0], h[HASH_W-1:HASH_W-5]} ^ HASH_W'(chars.ch);
            lastf <= chars.last_char;
            if (32'(klen) < 32'(MAX_NAME_LEN)) begin
              kbuf[klen[KW-1:0]] <= chars.ch;
            end
            if (32'(klen) <= 32'(MAX_NAME_LEN)) begin
              klen <= klen + 1'b1;
            end
            state <= S_MA;
          end
        end
        S_MA: begin
          p0    <= x[31:0] * HASH_MUL[31:0];
          state <= S_MB;
        end
        S_MB: begin
          p1    <= 32'(x[31:0] * HASH_MUL[63:32]);
          state <= S_MC;
        end
        S_MC: begin
          p2    <= 32'(x[63:32] * HASH_MUL[31:0]);
          state <= S_SUM;
        end
        S_SUM: begin
          h <= p0 + {p1 + p2, 32'b0};
          if (!lastf) begin
            state <= S_IDLE;
          end else if (32'(klen) > 32'(MAX_NAME_LEN)) begin
            res_id     <= '0;
            res_new    <= 1'b0;
            res_status <= ST_TOO_LONG;
            state      <= S_EMIT;
          end else begin
            nreg   <= n_eff;
            rem    <= '0;
            bitcnt <= 6'd63;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= rem_next;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == '0) begin
            idx    <= rem_next[IW-1:0];
            probes <= '0;
            state  <= S_PRD;
          end
        end
        S_PRD: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (!slot_rdata.valid) begin
            if (32'(next_number) >= 32'(TABLE_SLOTS)) begin
              res_id     <= '0;
              res_new    <= 1'b0;
              res_status <= ST_FULL;
              state      <= S_EMIT;
            end else begin
              ci    <= '0;
              state <= S_COPY;
            end
          end else if (slot_rdata.hash == h && slot_rdata.len == klen) begin
            snum  <= slot_rdata.num;
            ci    <= '0;
            state <= S_CRD;
          end else if (probes + 1'b1 == nreg) begin
            res_id     <= '0;
            res_new    <= 1'b0;
            res_status <= ST_FULL;
            state      <= S_EMIT;
          end else begin
            probes <= probes + 1'b1;
            idx    <= idx_wrap;
            state  <= S_PRD;
          end
        end
        S_CRD: begin
          state <= S_CCHK;
        end
        S_CCHK: begin
          if (name_rdata != kbuf[ci[KW-1:0]]) begin
            if (probes + 1'b1 == nreg) begin
              res_id     <= '0;
              res_new    <= 1'b0;
              res_status <= ST_FULL;
              state      <= S_EMIT;
            end else begin
              probes <= probes + 1'b1;
              idx    <= idx_wrap;
              state  <= S_PRD;
            end
          end else if (ci + 1'b1 == klen) begin
            res_id     <= snum;
            res_new    <= 1'b0;
            res_status <= ST_OK;
            state      <= S_EMIT;
          end else begin
            ci    <= ci + 1'b1;
            state <= S_CRD;
          end
        end
        S_COPY: begin
          if (ci + 1'b1 == klen) begin
            res_id      <= next_number;
            res_new     <= 1'b1;
            res_status  <= ST_OK;
            next_number <= next_number + 1'b1;
            state       <= S_EMIT;
          end else begin
            ci <= ci + 1'b1;
          end
        end
        S_EMIT: begin
          if (!result.valid || result.ready) begin
            result.valid  <= 1'b1;
            result.sym_id <= IDENT_W'(res_id);
            result.is_new <= res_new;
            result.status <= res_status;
            h             <= '0;
            klen          <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/identifier_interning_table_tb.sv
module identifier_interning_table_tb;
  import iit_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int NAME_MAX = MAX_NAME_LEN_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int QUIET_CYCLES = 1200;

  typedef logic [CH_W-1:0] name_t[$];

  typedef struct packed {
    logic [IDENT_W-1:0]  sym_id;
    logic                is_new;
    logic [STATUS_W-1:0] status;
  } ident_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  iit_char_if chars_if ();
  iit_res_if  res_if ();

  identifier_interning_table u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // shadow of the interning table
  logic [SLOTS_W-1:0] slots_reg;
  bit                 slot_valid[SLOTS];
  logic [HASH_W-1:0]  slot_hash[SLOTS];
  int                 slot_len[SLOTS];
  int                 slot_num[SLOTS];
  logic [CH_W-1:0]    name_store[SLOTS*NAME_MAX];
  logic [CH_W-1:0]    key_buf[NAME_MAX];
  int                 key_len;
  logic [HASH_W-1:0]  key_hash;
  int                 next_num;

  ident_result_t pending_results[$];

  int errors;
  int cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_len;
  bit hold_req;
  bit hold_ack = 1'b0;
  int holdoff_left = 0;
  int n_inserted, n_found, n_full, n_too_long, n_chars, n_skipped;

  name_t vocab[40];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      holdoff_left <= holdoff_len;
      hold_ack <= hold_req;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    ident_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result, sym_id", res_if.sym_id, -1);
      end else begin
        want = pending_results.pop_front();
        if (res_if.sym_id !== want.sym_id)
          report("sym_id", res_if.sym_id, want.sym_id);
        if (res_if.is_new !== want.is_new)
          report("is_new", res_if.is_new, want.is_new);
        if (res_if.status !== want.status)
          report("status", res_if.status, want.status);
      end
    end
  end

  function automatic bit stored_name_matches(int num, int len);
    for (int i = 0; i < len; i++)
      if (name_store[num*NAME_MAX + i] !== key_buf[i]) return 1'b0;
    return 1'b1;
  endfunction

  // fold one accepted byte into the shadow; queue a result on the last byte
  task automatic intern_char(input logic [CH_W-1:0] c, input bit last);
    logic [HASH_W-1:0] h;
    ident_result_t r;
    int len, n, idx;
    bit done;
    h = {key_hash[HASH_W-6:0], key_hash[HASH_W-1:HASH_W-5]};
    key_hash = (h ^ {{(HASH_W-CH_W){1'b0}}, c}) * HASH_MUL;
    if (key_len < NAME_MAX) key_buf[key_len] = c;
    if (key_len <= NAME_MAX) key_len++;
    if (last) begin
      h = key_hash;
      len = key_len;
      key_hash = '0;
      key_len = 0;
      r = '{sym_id: '0, is_new: 1'b0, status: ST_OK};
      done = 1'b0;
      if (len > NAME_MAX) begin
        r.status = ST_TOO_LONG;
        n_too_long++;
        done = 1'b1;
      end
      n = slots_reg;
      if (n == 0) n = 1;
      if (n > SLOTS) n = SLOTS;
      idx = h % n;
      for (int p = 0; p < n && !done; p++) begin
        if (!slot_valid[idx]) begin
          slot_valid[idx] = 1'b1;
          slot_hash[idx] = h;
          slot_len[idx] = len;
          slot_num[idx] = next_num;
          for (int i = 0; i < len; i++) name_store[next_num*NAME_MAX + i] = key_buf[i];
          r.sym_id = IDENT_W'(next_num);
          r.is_new = 1'b1;
          next_num++;
          n_inserted++;
          done = 1'b1;
        end else if (slot_hash[idx] == h && slot_len[idx] == len &&
                     stored_name_matches(slot_num[idx], len)) begin
          r.sym_id = IDENT_W'(slot_num[idx]);
          n_found++;
          done = 1'b1;
        end
        idx++;
        if (idx >= n) idx = 0;
      end
      if (!done) begin
        r.status = ST_FULL;
        n_full++;
      end
      pending_results.push_back(r);
    end
  endtask

  task automatic send_char(input logic [CH_W-1:0] c, input bit last, input bit skip_it);
    if ($urandom_range(99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch <= c;
    chars_if.last_char <= last;
    chars_if.skip <= skip_it;
    do @(posedge clk); while (!chars_if.ready);
    if (skip_it) begin
      n_skipped++;
    end else begin
      n_chars++;
      intern_char(c, last);
    end
  endtask

  task automatic send_name(input name_t nm, input int noise_pct);
    for (int i = 0; i < nm.size(); i++) begin
      if ($urandom_range(99) < noise_pct)
        send_char(CH_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      send_char(nm[i], i == nm.size() - 1, 1'b0);
    end
  endtask

  function automatic name_t random_name(input int len);
    name_t nm;
    for (int i = 0; i < len; i++) nm.push_back(CH_W'($urandom_range(255)));
    return nm;
  endfunction

  function automatic int random_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(8, 1);
    if (pick < 93) return $urandom_range(NAME_MAX, 9);
    return $urandom_range(NAME_MAX + 8, NAME_MAX + 1);
  endfunction

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    chars_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_slots(input int value);
    logic [PDATA_W-1:0] rd;
    wait_idle();
    apb_write(REG_SLOTS_IN_USE, value);
    slots_reg = SLOTS_W'(value);
    apb_read(REG_SLOTS_IN_USE, rd);
    if (rd[SLOTS_W-1:0] !== slots_reg)
      report("slots_in_use readback", rd[SLOTS_W-1:0], slots_reg);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed();
    name_t nm;
    set_idling(0, 0);
    nm = '{8'h00};
    send_name(nm, 0);
    nm = '{8'hff};
    send_name(nm, 0);
    send_name(nm, 0);
    send_char(8'h41, 1'b1, 1'b1);
    send_char(8'h5a, 1'b0, 1'b1);
    send_char(8'h61, 1'b0, 1'b0);
    send_char(8'h62, 1'b1, 1'b1);
    send_char(8'h62, 1'b1, 1'b0);
    send_name(random_name(NAME_MAX), 0);
    send_name(random_name(NAME_MAX + 1), 0);
  endtask

  // one usable slot: a second name finds the table full; zero acts as one
  task automatic test_full_table();
    name_t first, other;
    first = random_name(3);
    other = random_name(4);
    set_slots(1);
    send_name(first, 0);
    send_name(first, 0);
    send_name(other, 0);
    set_slots(0);
    send_name(other, 0);
    send_name(first, 0);
    set_slots(2);
    send_name(other, 0);
  endtask

  task automatic test_random_traffic(input int slots, input int n_items,
                                     input int send_pct, input int recv_pct);
    int goal;
    set_slots(slots);
    set_idling(send_pct, recv_pct);
    goal = n_chars + n_items;
    while (n_chars < goal) begin
      if ($urandom_range(99) < 60)
        send_name(vocab[$urandom_range(39)], 8);
      else
        send_name(random_name(random_len()), 8);
    end
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    holdoff_len = 400;
    hold_req = ~hold_req;
    for (int i = 0; i < 12; i++) send_name(vocab[$urandom_range(39)], 0);
    chars_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    for (int i = 0; i < 6; i++) send_name(random_name($urandom_range(4, 1)), 0);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    chars_if.valid = 1'b0;
    chars_if.ch = '0;
    chars_if.last_char = 1'b0;
    chars_if.skip = 1'b0;
    errors = 0;
    hold_req = 1'b0;
    holdoff_len = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    slots_reg = SLOTS_RESET;
    key_len = 0;
    key_hash = '0;
    next_num = 0;
    for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
    for (int i = 0; i < 40; i++) vocab[i] = random_name($urandom_range(12, 1));
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_table();
    test_random_traffic(2047, 80, 0, 0);
    test_random_traffic(SLOTS, 80, 48, 0);
    test_random_traffic(7, 60, 0, 48);
    test_random_traffic(300, 80, 36, 36);
    test_backpressure();
    test_random_traffic(SLOTS, 40, 48, 48);

    wait_idle();
    $display("%0d identifier bytes and %0d skipped items over several table sizes",
             n_chars, n_skipped);
    $display("results: %0d new, %0d found, %0d full, %0d too long; %0d mismatches",
             n_inserted, n_found, n_full, n_too_long, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> identifier_interning_table.f
hw/rtl/iit_pkg.sv
hw/rtl/iit_if.sv
hw/rtl/iit_ram.sv
hw/rtl/identifier_interning_table.sv
tb/identifier_interning_table_tb.sv
